[hw/rtl/xee_pkg.sv]
// Package for the XML entity escaper: character codes, run descriptor type, queue depth.
`default_nettype none
package xee_pkg;

   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int RUN_MAX         = 6;
   localparam int RUN_IDX_W       = $clog2(RUN_MAX);

   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_QUOT  = 8'h22;
   localparam logic [7:0] CH_APOS  = 8'h27;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_M     = 8'h6D;
   localparam logic [7:0] CH_P     = 8'h70;
   localparam logic [7:0] CH_L     = 8'h6C;
   localparam logic [7:0] CH_G     = 8'h67;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_Q     = 8'h71;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_O     = 8'h6F;
   localparam logic [7:0] CH_3     = 8'h33;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CTRL_TOP = 8'd32;
   localparam logic [7:0] ASCII_TOP = 8'd127;

   // One input byte's escaped form: bytes[0] goes out first.
   typedef struct packed {
      logic [RUN_MAX-1:0][7:0] bytes;
      logic [RUN_IDX_W-1:0]    len;
      logic                    eot;
   } run_desc_type;

endpackage
`default_nettype wire

[hw/rtl/xee_front.sv]
// Front end: holds the passthrough register and turns each input byte into a run descriptor.
`default_nettype none
module xee_front import xee_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wen,
   input  wire logic         csr_wdata,
   input  wire logic [7:0]   text_byte,
   input  wire logic         end_of_text,
   output run_desc_type      desc
);

   logic        utf8_ff;
   logic        utf8_in;
   logic [1:0]  hund;
   logic [6:0]  rem;
   logic [14:0] prod;
   logic [3:0]  tens;
   logic [3:0]  ones;
   logic        numeric;

   assign utf8_in = csr_wen ? csr_wdata : utf8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         utf8_ff <= 1'b0;
      end else begin
         utf8_ff <= utf8_in;
      end
   end

   // decimal digits; rem < 100 so (rem * 205) >> 11 is rem / 10
   always_comb begin
      if (text_byte >= 8'd200) begin
         hund = 2'd2;
         rem  = 7'(text_byte - 8'd200);
      end else if (text_byte >= 8'd100) begin
         hund = 2'd1;
         rem  = 7'(text_byte - 8'd100);
      end else begin
         hund = 2'd0;
         rem  = text_byte[6:0];
      end
      prod = 15'(rem) * 15'd205;
      tens = prod[14:11];
      ones = 4'(rem - 7'(tens) * 7'd10);
   end

   assign numeric = (text_byte < CTRL_TOP) || (!utf8_ff && (text_byte > ASCII_TOP));

   always_comb begin
      desc          = '0;
      desc.eot      = end_of_text;
      desc.len      = RUN_IDX_W'(1);
      desc.bytes[0] = text_byte;
      case (text_byte)
         CH_AMP: begin
            desc.bytes = {8'h00, CH_SEMI, CH_P, CH_M, CH_A, CH_AMP};
            desc.len   = RUN_IDX_W'(5);
         end
         CH_LT: begin
            desc.bytes = {8'h00, 8'h00, CH_SEMI, CH_T, CH_L, CH_AMP};
            desc.len   = RUN_IDX_W'(4);
         end
         CH_GT: begin
            desc.bytes = {8'h00, 8'h00, CH_SEMI, CH_T, CH_G, CH_AMP};
            desc.len   = RUN_IDX_W'(4);
         end
         CH_QUOT: begin
            desc.bytes = {CH_SEMI, CH_T, CH_O, CH_U, CH_Q, CH_AMP};
            desc.len   = RUN_IDX_W'(6);
         end
         CH_APOS: begin
            desc.bytes = {8'h00, CH_SEMI, CH_9, CH_3, CH_HASH, CH_AMP};
            desc.len   = RUN_IDX_W'(5);
         end
         CH_NL: begin
            desc.len = RUN_IDX_W'(1);
         end
         default: begin
            if (numeric) begin
               if (text_byte >= 8'd100) begin
                  desc.bytes = {CH_SEMI, CH_ZERO | 8'(ones), CH_ZERO | 8'(tens),
                                CH_ZERO | 8'(hund), CH_HASH, CH_AMP};
                  desc.len   = RUN_IDX_W'(6);
               end else if (text_byte >= 8'd10) begin
                  desc.bytes = {8'h00, CH_SEMI, CH_ZERO | 8'(ones), CH_ZERO | 8'(tens),
                                CH_HASH, CH_AMP};
                  desc.len   = RUN_IDX_W'(5);
               end else begin
                  desc.bytes = {8'h00, 8'h00, CH_SEMI, CH_ZERO | 8'(ones),
                                CH_HASH, CH_AMP};
                  desc.len   = RUN_IDX_W'(4);
               end
            end
         end
      endcase
   end

endmodule
`default_nettype wire

[hw/rtl/xee_queue.sv]
// Small register queue of run descriptors between front and back.
`default_nettype none
module xee_queue import xee_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  wr_en,
   input  wire run_desc_type wr_data,
   input  wire logic  rd_en,
   output run_desc_type rd_data,
   output logic       q_full,
   output logic       q_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   run_desc_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   do_wr, do_rd;

   assign q_full  = (cnt_ff == CNT_W'(DEPTH));
   assign q_empty = (cnt_ff == '0);
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/xee_back.sv]
// Back end: walks a run descriptor one byte per cycle into the output register while pop keeps up.
`default_nettype none
module xee_back import xee_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire run_desc_type q_data,
   input  wire logic       q_empty,
   output logic            q_pop,
   input  wire logic       pop,
   output logic            empty,
   output logic [7:0]      out_byte,
   output logic            run_last,
   output logic            text_last
);

   run_desc_type          run_ff, run_in;
   logic                  run_valid_ff, run_valid_in;
   logic [RUN_IDX_W-1:0]  idx_ff, idx_in;
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            out_byte_ff;
   logic                  run_last_ff, text_last_ff;
   logic                  adv, at_end, load;

   always_comb begin
      adv    = run_valid_ff && (!out_valid_ff || pop);
      at_end = (idx_ff == run_ff.len - RUN_IDX_W'(1));
      // reload in the same cycle the last byte of a run moves out
      load   = !q_empty && (!run_valid_ff || (adv && at_end));

      run_in       = load ? q_data : run_ff;
      run_valid_in = run_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         run_valid_in = 1'b1;
         idx_in       = '0;
      end else if (adv) begin
         run_valid_in = !at_end;
         idx_in       = idx_ff + RUN_IDX_W'(1);
      end

      out_valid_in = out_valid_ff;
      if (adv) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         run_valid_ff <= run_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
      if (adv) begin
         out_byte_ff  <= run_ff.bytes[idx_ff];
         run_last_ff  <= at_end;
         text_last_ff <= at_end && run_ff.eot;
      end
   end

   assign q_pop     = load;
   assign empty     = !out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign run_last  = run_last_ff;
   assign text_last = text_last_ff;

endmodule
`default_nettype wire

[hw/rtl/xml_entity_escaper_top.sv]
// Top level of the XML entity escaper: front classifier, descriptor queue, byte emitter.
//
//   channel  | ports                                        | beat taken when
//   ---------+----------------------------------------------+-------------------
//   request  | push, full, req_text_byte, req_end_of_text   | push && !full
//   response | pop, empty, rsp_out_byte, rsp_run_last,      | pop && !empty
//            | rsp_text_last                                |
//   csr      | csr_wen, csr_wdata                           | csr_wen
//
// A plain byte gives one output byte, an escaped byte 4 to 6; the back end emits
// them one byte per cycle while pop does not stall. A beat's first output byte
// goes through queue, run and output registers. The descriptor queue (QUEUE_DEPTH
// entries) lets the request side run ahead while a run drains or pop stalls.
// Synchronous reset empties the queue and output stage and clears the passthrough bit utf8_ff.
`default_nettype none
module xml_entity_escaper_top import xee_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        req_end_of_text,
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_last,
   output logic             rsp_text_last,
   input  wire logic        csr_wen,
   input  wire logic        csr_wdata
);

   run_desc_type front_desc;
   run_desc_type q_data;
   logic         q_empty;
   logic         q_pop;

   xee_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .desc        (front_desc)
   );

   xee_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (front_desc),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .q_full  (full),
      .q_empty (q_empty)
   );

   xee_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_data    (q_data),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .pop       (pop),
      .empty     (empty),
      .out_byte  (rsp_out_byte),
      .run_last  (rsp_run_last),
      .text_last (rsp_text_last)
   );

endmodule
`default_nettype wire

[hw/rtl/xee_checker.sv]
// Port-level checker for the XML entity escaper, bound to the top level.
`default_nettype none
module xee_checker import xee_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       full,
   input  wire logic       empty,
   input  wire logic       pop,
   input  wire logic [7:0] rsp_out_byte,
   input  wire logic       rsp_run_last,
   input  wire logic       rsp_text_last
);

   // reset leaves both sides idle
   a_reset_idle: assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("not idle after reset");

   // end of text only on the closing byte of a run
   a_text_in_run: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_text_last) |-> rsp_run_last)
      else $error("text_last without run_last");

   // a semicolon only ever appears as the last byte of a run
   a_semi_closes: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_run_last) |-> (rsp_out_byte != CH_SEMI))
      else $error("semicolon inside a run");

   // an unpopped beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_byte) && $stable(rsp_run_last)))
      else $error("stalled beat changed");

endmodule

bind xml_entity_escaper_top xee_checker u_xee_checker (
   .clock         (clock),
   .reset         (reset),
   .full          (full),
   .empty         (empty),
   .pop           (pop),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_run_last  (rsp_run_last),
   .rsp_text_last (rsp_text_last)
);
`default_nettype wire
